// File: hdl/flrd_pkg.sv
// Shared types and constants of the framed link receive deframer.
// Used by flrd_core and framed_link_receive_deframer; depends on nothing.

package flrd_pkg;

    localparam int PAYLOAD_LIMIT = 1024;
    localparam int MAX_FRAME     = 1037;
    localparam int HDR_LEN       = 10;

    localparam int SPAN  = (MAX_FRAME > PAYLOAD_LIMIT + HDR_LEN + 2) ?
                           MAX_FRAME : PAYLOAD_LIMIT + HDR_LEN + 2;
    localparam int CNT_W = $clog2(SPAN + 1);

    localparam logic [7:0]  SYNC_A    = 8'hA5;
    localparam logic [7:0]  SYNC_B    = 8'h5A;
    localparam logic [7:0]  TAIL_BYTE = 8'h7E;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    localparam int M_TDATA_W = 64;

    typedef enum logic [1:0] {
        CFG_RX_ENABLE = 2'd0,
        CFG_DEV_ADDR  = 2'd1,
        CFG_VERSION   = 2'd2,
        CFG_UNUSED    = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_BAD      = 3'd1,
        STAT_ADDR     = 3'd2,
        STAT_LEN      = 3'd3,
        STAT_OVERFLOW = 3'd4
    } status_t;

    typedef enum logic {
        OP_BYTE  = 1'b0,
        OP_RESYNC = 1'b1
    } op_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef struct packed {
        logic       enable;
        logic [7:0] address;
        logic [7:0] version;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  payload_byte;
        status_t     status;
        logic [7:0]  frame_type;
        logic [7:0]  command_code;
        logic [15:0] sequence_number;
        logic [15:0] length_field;
    } result_t;

endpackage

// File: hdl/flrd_core.sv
// Frame tracking core: sync hunt, header capture with payload length limit, CRC-16 and frame end checks.
// Depends on flrd_pkg; instantiated by framed_link_receive_deframer.

module flrd_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  flrd_pkg::cfg_t    cfg,
    input  logic              cfg_drop,
    input  logic              item_valid,
    input  flrd_pkg::op_t     item_op,
    input  logic [7:0]        item_byte,
    input  logic              step,
    output flrd_pkg::result_t res
);

    localparam int CW = flrd_pkg::CNT_W;

    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic [15:0]   crc_reg, crc_next;
    logic [7:0]    held_version_reg, held_version_next;
    logic [7:0]    held_address_reg, held_address_next;
    logic [15:0]   held_sequence_reg, held_sequence_next;
    logic [7:0]    held_type_reg, held_type_next;
    logic [7:0]    held_command_reg, held_command_next;
    logic [15:0]   held_length_reg, held_length_next;
    logic [7:0]    crc_low_reg, crc_low_next;

    logic [CW-1:0] frame_end;
    logic [15:0]   crc_of_byte;
    logic          emit;
    flrd_pkg::kind_t   emit_kind;
    flrd_pkg::status_t emit_status;
    logic [7:0]    emit_byte;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ flrd_pkg::CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    assign crc_of_byte = crc_byte(crc_reg, item_byte);
    assign frame_end   = CW'(flrd_pkg::HDR_LEN) + held_length_reg[CW-1:0];

    always_comb begin
        byte_count_next    = byte_count_reg;
        crc_next           = crc_reg;
        held_version_next  = held_version_reg;
        held_address_next  = held_address_reg;
        held_sequence_next = held_sequence_reg;
        held_type_next     = held_type_reg;
        held_command_next  = held_command_reg;
        held_length_next   = held_length_reg;
        crc_low_next       = crc_low_reg;
        emit               = 1'b0;
        emit_kind          = flrd_pkg::KIND_PAYLOAD;
        emit_status        = flrd_pkg::STAT_OK;
        emit_byte          = 8'h00;

        if (item_op == flrd_pkg::OP_RESYNC) begin
            byte_count_next = '0;
        end else if (cfg.enable) begin
            if (byte_count_reg == '0) begin
                if (item_byte == flrd_pkg::SYNC_A) begin
                    byte_count_next = CW'(1);
                end
            end else if (byte_count_reg == CW'(1)) begin
                if (item_byte == flrd_pkg::SYNC_B) begin
                    byte_count_next = CW'(2);
                    crc_next        = flrd_pkg::CRC_INIT;
                end else if (item_byte != flrd_pkg::SYNC_A) begin
                    byte_count_next = '0;
                end
            end else if (byte_count_reg >= CW'(flrd_pkg::MAX_FRAME)) begin
                byte_count_next = '0;
                emit            = 1'b1;
                emit_kind       = flrd_pkg::KIND_STATUS;
                emit_status     = flrd_pkg::STAT_OVERFLOW;
            end else begin
                byte_count_next = byte_count_reg + CW'(1);
                if (byte_count_reg < CW'(flrd_pkg::HDR_LEN)) begin
                    crc_next = crc_of_byte;
                    unique case (byte_count_reg)
                        CW'(2): held_version_next = item_byte;
                        CW'(3): held_address_next = item_byte;
                        CW'(4): held_sequence_next = {8'h00, item_byte};
                        CW'(5): held_sequence_next = {item_byte, held_sequence_reg[7:0]};
                        CW'(6): held_type_next = item_byte;
                        CW'(7): held_command_next = item_byte;
                        CW'(8): held_length_next = {8'h00, item_byte};
                        default: held_length_next = {item_byte, held_length_reg[7:0]};
                    endcase
                    if (byte_count_reg == CW'(flrd_pkg::HDR_LEN - 1) &&
                        held_length_next > 16'(flrd_pkg::PAYLOAD_LIMIT)) begin
                        byte_count_next = '0;
                        emit            = 1'b1;
                        emit_kind       = flrd_pkg::KIND_STATUS;
                        emit_status     = flrd_pkg::STAT_LEN;
                    end
                end else if (byte_count_reg < frame_end) begin
                    crc_next  = crc_of_byte;
                    emit      = 1'b1;
                    emit_byte = item_byte;
                end else if (byte_count_reg == frame_end) begin
                    crc_low_next = item_byte;
                end else if (byte_count_reg == frame_end + CW'(1)) begin
                    crc_next = crc_reg ^ {item_byte, crc_low_reg};
                end else begin
                    byte_count_next = '0;
                    emit            = 1'b1;
                    emit_kind       = flrd_pkg::KIND_STATUS;
                    priority if (item_byte != flrd_pkg::TAIL_BYTE || crc_reg != 16'h0000 ||
                                 held_version_reg != cfg.version) begin
                        emit_status = flrd_pkg::STAT_BAD;
                    end else if (held_address_reg != cfg.address) begin
                        emit_status = flrd_pkg::STAT_ADDR;
                    end else begin
                        emit_status = flrd_pkg::STAT_OK;
                    end
                end
            end
        end

        res.valid           = item_valid && emit;
        res.kind            = emit_kind;
        res.payload_byte    = emit_byte;
        res.status          = emit_status;
        res.frame_type      = held_type_next;
        res.command_code    = held_command_next;
        res.sequence_number = held_sequence_next;
        res.length_field    = held_length_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            crc_reg        <= flrd_pkg::CRC_INIT;
        end else if (cfg_drop) begin
            byte_count_reg <= '0;
        end else if (step) begin
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && !cfg_drop) begin
            held_version_reg  <= held_version_next;
            held_address_reg  <= held_address_next;
            held_sequence_reg <= held_sequence_next;
            held_type_reg     <= held_type_next;
            held_command_reg  <= held_command_next;
            held_length_reg   <= held_length_next;
            crc_low_reg       <= crc_low_next;
        end
    end

endmodule

// File: hdl/framed_link_receive_deframer.sv
// Top level of the framed link receive deframer: stream ports, config registers,
// input and result registers. Depends on flrd_pkg and flrd_core.

// Each received byte is held in an input register, runs combinationally through
// the frame tracker and byte-wide CRC-16/CCITT-FALSE, and its result (a payload
// byte, or a status ending the frame) lands in the output register, so a byte can
// be accepted every cycle but for the stall below. While a result waits in the output register,
// bytes that give no result still pass; a byte that gives a result holds in the input
// register, and the input stalls, until the waiting result is taken.
// Frames are sync 0xA5 0x5A, version, address, sequence (LE), type, command, length (LE),
// payload, CRC (LE) and a 0x7E tail; a repeated 0xA5 keeps the sync hunt armed.
// Config writes are taken at any time, but are meant for an idle block; writing the
// enable register drops any partial frame.

module framed_link_receive_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    input  logic        s_tuser,   // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // payload_byte[7:0], frame_status[10:8], frame_type[18:11],
                                   // command_code[26:19], sequence_number[42:27],
                                   // frame_payload_length[58:43], zero[63:59]
    output logic        m_tuser,   // kind[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    flrd_pkg::cfg_t    cfg_reg;
    logic              cfg_write;
    logic              cfg_drop;

    logic              in_valid_reg;
    flrd_pkg::op_t     in_op_reg;
    logic [7:0]        in_byte_reg;

    logic              out_valid_reg;
    logic              out_kind_reg;
    logic [flrd_pkg::M_TDATA_W-1:0] out_data_reg;

    flrd_pkg::result_t res;
    logic              core_fire;
    logic              s_fire;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_drop  = cfg_write && flrd_pkg::cfg_index_t'(cfg_index) == flrd_pkg::CFG_RX_ENABLE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable  <= 1'b0;
            cfg_reg.address <= 8'h00;
            cfg_reg.version <= 8'h02;
        end else if (cfg_write) begin
            unique case (flrd_pkg::cfg_index_t'(cfg_index))
                flrd_pkg::CFG_RX_ENABLE: cfg_reg.enable  <= cfg_data[0];
                flrd_pkg::CFG_DEV_ADDR:  cfg_reg.address <= cfg_data;
                flrd_pkg::CFG_VERSION:   cfg_reg.version <= cfg_data;
                default: ;
            endcase
        end
    end

    // Bytes that give no result pass even while the output is stalled.
    assign core_fire = in_valid_reg && (!res.valid || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || core_fire;
    assign s_fire    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (core_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_op_reg   <= flrd_pkg::op_t'(s_tuser);
            in_byte_reg <= s_tdata;
        end
    end

    flrd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .cfg_drop   (cfg_drop),
        .item_valid (in_valid_reg),
        .item_op    (in_op_reg),
        .item_byte  (in_byte_reg),
        .step       (core_fire),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (core_fire && res.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_fire && res.valid) begin
            out_kind_reg <= res.kind;
            out_data_reg <= {5'b00000, res.length_field, res.sequence_number,
                             res.command_code, res.frame_type, res.status, res.payload_byte};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = out_data_reg;

    a_payload_no_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == flrd_pkg::KIND_PAYLOAD |-> m_tdata[10:8] == flrd_pkg::STAT_OK)
        else $error("payload transfer carries a status code");

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == flrd_pkg::KIND_STATUS |->
            m_tdata[7:0] == 8'h00 && m_tdata[10:8] <= flrd_pkg::STAT_OVERFLOW)
        else $error("status transfer malformed");

    a_len_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == flrd_pkg::KIND_STATUS && m_tdata[10:8] == flrd_pkg::STAT_LEN
            |-> m_tdata[58:43] > 16'(flrd_pkg::PAYLOAD_LIMIT))
        else $error("length status with legal length");

    a_disabled_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        core_fire && !cfg_reg.enable |-> !res.valid)
        else $error("result produced while receiver disabled");

    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        core_fire && res.valid |=> m_tvalid)
        else $error("result lost before output register");

endmodule

// File: tb/sv/framed_link_receive_deframer_test.sv
`timescale 1ns / 100ps
// Testbench for framed_link_receive_deframer: directed and random byte streams checked
// against an in-bench predictor of sync hunt, header capture, CRC-16 and frame status.
// Depends on flrd_pkg and the deframer RTL.

module framed_link_receive_deframer_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;

    typedef enum {FLAW_NONE, FLAW_CRC, FLAW_TAIL, FLAW_CUT, FLAW_PAUSE} frame_flaw_t;

    typedef struct {
        flrd_pkg::kind_t   kind;
        logic [7:0]        payload_byte;
        flrd_pkg::status_t status;
        logic [7:0]        frame_type;
        logic [7:0]        command_code;
        logic [15:0]       sequence_number;
        logic [15:0]       length_field;
    } rx_out_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;

    // predicted deframer state
    logic        rx_enable    = 1'b0;
    logic [7:0]  own_address  = 8'h00;
    logic [7:0]  want_version = 8'h02;
    int unsigned frame_pos    = 0;
    logic [15:0] crc_acc      = 16'hFFFF;
    logic [7:0]  hdr_version  = '0;
    logic [7:0]  hdr_address  = '0;
    logic [7:0]  hdr_type     = '0;
    logic [7:0]  hdr_command  = '0;
    logic [7:0]  crc_lo_byte  = '0;
    logic [15:0] hdr_sequence = '0;
    logic [15:0] hdr_length   = '0;

    rx_out_t     expected_out[$];
    logic [7:0]  frame_body[$];
    int          idling_on    = 1;
    int          hold_request = 0;
    int          errors       = 0;
    int          bytes_sent   = 0;
    int          frames_sent  = 0;
    int          results_seen = 0;
    int          cycles       = 0;

    framed_link_receive_deframer dut (.*);

    initial forever #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("framed_link_receive_deframer_test: done, errors");
            $finish;
        end
    end

    function automatic logic [15:0] crc16_ccitt(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            c = c[15] ? ((c << 1) ^ flrd_pkg::CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic void expect_result(flrd_pkg::kind_t kind, logic [7:0] pbyte,
                                          flrd_pkg::status_t status);
        rx_out_t r;
        r.kind            = kind;
        r.payload_byte    = pbyte;
        r.status          = status;
        r.frame_type      = hdr_type;
        r.command_code    = hdr_command;
        r.sequence_number = hdr_sequence;
        r.length_field    = hdr_length;
        expected_out.push_back(r);
    endfunction

    function automatic void deframe_byte(flrd_pkg::op_t op, logic [7:0] b);
        int unsigned pos;
        int unsigned body_end;
        if (op == flrd_pkg::OP_RESYNC) begin
            frame_pos = 0;
            return;
        end
        if (!rx_enable)
            return;
        if (frame_pos == 0) begin
            if (b == flrd_pkg::SYNC_A)
                frame_pos = 1;
            return;
        end
        if (frame_pos == 1) begin
            if (b == flrd_pkg::SYNC_B) begin
                frame_pos = 2;
                crc_acc   = flrd_pkg::CRC_INIT;
            end else if (b != flrd_pkg::SYNC_A) begin
                frame_pos = 0;
            end
            return;
        end
        if (frame_pos >= flrd_pkg::MAX_FRAME) begin
            frame_pos = 0;
            expect_result(flrd_pkg::KIND_STATUS, 8'h00, flrd_pkg::STAT_OVERFLOW);
            return;
        end
        pos = frame_pos;
        frame_pos++;
        if (pos < flrd_pkg::HDR_LEN) begin
            crc_acc = crc16_ccitt(crc_acc, b);
            case (pos)
                2: hdr_version = b;
                3: hdr_address = b;
                4: hdr_sequence[7:0] = b;
                5: hdr_sequence[15:8] = b;
                6: hdr_type = b;
                7: hdr_command = b;
                8: hdr_length[7:0] = b;
                default: begin
                    hdr_length[15:8] = b;
                    if (hdr_length > flrd_pkg::PAYLOAD_LIMIT) begin
                        frame_pos = 0;
                        expect_result(flrd_pkg::KIND_STATUS, 8'h00, flrd_pkg::STAT_LEN);
                    end
                end
            endcase
            return;
        end
        body_end = flrd_pkg::HDR_LEN + hdr_length;
        if (pos < body_end) begin
            crc_acc = crc16_ccitt(crc_acc, b);
            expect_result(flrd_pkg::KIND_PAYLOAD, b, flrd_pkg::STAT_OK);
        end else if (pos == body_end) begin
            crc_lo_byte = b;
        end else if (pos == body_end + 1) begin
            crc_acc ^= {b, crc_lo_byte};
        end else begin
            frame_pos = 0;
            if (b != flrd_pkg::TAIL_BYTE || crc_acc != 16'h0000 || hdr_version != want_version)
                expect_result(flrd_pkg::KIND_STATUS, 8'h00, flrd_pkg::STAT_BAD);
            else if (hdr_address != own_address)
                expect_result(flrd_pkg::KIND_STATUS, 8'h00, flrd_pkg::STAT_ADDR);
            else
                expect_result(flrd_pkg::KIND_STATUS, 8'h00, flrd_pkg::STAT_OK);
        end
    endfunction

    task automatic send_byte(flrd_pkg::op_t op, logic [7:0] b);
        if (idling_on != 0 && $urandom_range(0, 6) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        deframe_byte(op, b);
        bytes_sent++;
    endtask

    task automatic drain_results(int extra);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_out.size() != 0);
        repeat (extra) @(posedge aclk);
    endtask

    // caller drains first; registers are only written on an idle block
    task automatic write_reg(flrd_pkg::cfg_index_t idx, logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            flrd_pkg::CFG_RX_ENABLE: begin
                rx_enable = value[0];
                frame_pos = 0;
            end
            flrd_pkg::CFG_DEV_ADDR: own_address = value;
            flrd_pkg::CFG_VERSION:  want_version = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic fill_body(int n);
        frame_body.delete();
        repeat (n) frame_body.push_back(8'($urandom));
    endtask

    task automatic send_frame(logic [7:0] version, logic [7:0] address, logic [15:0] seq_num,
                              logic [7:0] ftype, logic [7:0] command, logic [15:0] length,
                              frame_flaw_t flaw);
        logic [7:0]  line_q[$];
        logic [15:0] crc;
        int          stop_at;
        int          pause_at;
        line_q = '{flrd_pkg::SYNC_A, flrd_pkg::SYNC_B, version, address, seq_num[7:0],
                   seq_num[15:8], ftype, command, length[7:0], length[15:8]};
        crc = flrd_pkg::CRC_INIT;
        for (int i = 2; i < line_q.size(); i++)
            crc = crc16_ccitt(crc, line_q[i]);
        if (length <= flrd_pkg::PAYLOAD_LIMIT) begin
            foreach (frame_body[i]) begin
                line_q.push_back(frame_body[i]);
                crc = crc16_ccitt(crc, frame_body[i]);
            end
            if (flaw == FLAW_CRC)
                crc ^= 16'($urandom_range(1, 65535));
            line_q.push_back(crc[7:0]);
            line_q.push_back(crc[15:8]);
            line_q.push_back(flaw == FLAW_TAIL ?
                             8'(flrd_pkg::TAIL_BYTE ^ $urandom_range(1, 255)) :
                             flrd_pkg::TAIL_BYTE);
        end
        stop_at  = (flaw == FLAW_CUT) ? $urandom_range(3, line_q.size() - 1) : line_q.size();
        pause_at = (flaw == FLAW_PAUSE) ? $urandom_range(10, line_q.size() - 1) : -1;
        for (int i = 0; i < stop_at; i++) begin
            if (i == pause_at)
                drain_results(0);
            send_byte(flrd_pkg::OP_BYTE, line_q[i]);
        end
        frames_sent++;
    endtask

    // receiver: random stall bursts, plus long hold-offs on request
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end else if (stall_left == 0 && idling_on != 0 && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 8);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        rx_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_out.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transfer: kind %0d data %h", m_tuser, m_tdata);
            end else begin
                want = expected_out.pop_front();
                if (m_tuser !== want.kind || m_tdata[7:0] !== want.payload_byte ||
                    m_tdata[10:8] !== want.status || m_tdata[18:11] !== want.frame_type ||
                    m_tdata[26:19] !== want.command_code ||
                    m_tdata[42:27] !== want.sequence_number ||
                    m_tdata[58:43] !== want.length_field) begin
                    errors++;
                    if (errors <= 10)
                        $display({"result %0d mismatch: exp kind %0d byte %h st %0d type %h ",
                                  "cmd %h seq %h len %h / got kind %0d byte %h st %0d type %h ",
                                  "cmd %h seq %h len %h"},
                                 results_seen, want.kind, want.payload_byte, want.status,
                                 want.frame_type, want.command_code, want.sequence_number,
                                 want.length_field, m_tuser, m_tdata[7:0], m_tdata[10:8],
                                 m_tdata[18:11], m_tdata[26:19], m_tdata[42:27],
                                 m_tdata[58:43]);
                end
            end
        end
    end

    task automatic test_disabled_rx();
        fill_body(3);
        send_frame(8'h02, 8'h00, 16'h0001, 8'h10, 8'h20, 16'd3, FLAW_NONE);
        send_byte(flrd_pkg::OP_RESYNC, 8'hFF);
        drain_results(SETTLE);
        write_reg(flrd_pkg::CFG_RX_ENABLE, 8'h01);
        // reset address and version must accept this one
        send_frame(8'h02, 8'h00, 16'h0000, 8'h00, 8'h00, 16'd3, FLAW_NONE);
    endtask

    task automatic test_header_extremes();
        drain_results(SETTLE);
        write_reg(flrd_pkg::CFG_DEV_ADDR, 8'hFF);
        write_reg(flrd_pkg::CFG_VERSION, 8'hFF);
        write_reg(flrd_pkg::CFG_UNUSED, 8'hFF);
        frame_body = '{8'h00, 8'hFF, flrd_pkg::TAIL_BYTE, flrd_pkg::SYNC_A, flrd_pkg::SYNC_B};
        send_frame(8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 16'd5, FLAW_NONE);
        frame_body.delete();
        send_frame(8'hFF, 8'hFF, 16'h0000, 8'h00, 8'h00, 16'd0, FLAW_NONE);
        drain_results(SETTLE);
        write_reg(flrd_pkg::CFG_DEV_ADDR, 8'h00);
        write_reg(flrd_pkg::CFG_VERSION, 8'h00);
        send_frame(8'h00, 8'h00, 16'h8001, 8'h5A, 8'hA5, 16'd0, FLAW_NONE);
    endtask

    task automatic test_frame_errors();
        drain_results(SETTLE);
        write_reg(flrd_pkg::CFG_DEV_ADDR, 8'h3C);
        write_reg(flrd_pkg::CFG_VERSION, 8'h02);
        fill_body(4);
        send_frame(8'h02, 8'h3C, 16'h1234, 8'h01, 8'h02, 16'd4, FLAW_TAIL);
        send_frame(8'h02, 8'h3C, 16'h1235, 8'h01, 8'h02, 16'd4, FLAW_CRC);
        send_frame(8'h03, 8'h3C, 16'h1236, 8'h01, 8'h02, 16'd4, FLAW_NONE);
        send_frame(8'h02, 8'h3D, 16'h1237, 8'h01, 8'h02, 16'd4, FLAW_NONE);
        // bad version outranks wrong address
        send_frame(8'h01, 8'h3D, 16'h1238, 8'h01, 8'h02, 16'd4, FLAW_NONE);
        send_frame(8'h02, 8'h3C, 16'h1239, 8'h01, 8'h02, 16'(flrd_pkg::PAYLOAD_LIMIT + 1),
                   FLAW_NONE);
        send_frame(8'h02, 8'h3C, 16'h123A, 8'h01, 8'h02, 16'hFFFF, FLAW_NONE);
        send_frame(8'h02, 8'h3C, 16'h123B, 8'h01, 8'h02, 16'd4, FLAW_PAUSE);
    endtask

    task automatic test_sync_hunt();
        fill_body(2);
        repeat (3) send_byte(flrd_pkg::OP_BYTE, flrd_pkg::SYNC_A);
        send_frame(8'h02, 8'h3C, 16'h0100, 8'h11, 8'h22, 16'd2, FLAW_NONE);
        send_byte(flrd_pkg::OP_BYTE, flrd_pkg::SYNC_A);
        send_byte(flrd_pkg::OP_BYTE, 8'h00);
        send_byte(flrd_pkg::OP_BYTE, flrd_pkg::SYNC_B);
        send_byte(flrd_pkg::OP_BYTE, flrd_pkg::TAIL_BYTE);
        send_frame(8'h02, 8'h3C, 16'h0101, 8'h11, 8'h22, 16'd2, FLAW_NONE);
        send_frame(8'h02, 8'h3C, 16'h0102, 8'h11, 8'h22, 16'd2, FLAW_CUT);
        send_byte(flrd_pkg::OP_RESYNC, 8'h00);
        send_byte(flrd_pkg::OP_BYTE, flrd_pkg::SYNC_A);
        send_byte(flrd_pkg::OP_RESYNC, 8'hA5);
        send_byte(flrd_pkg::OP_BYTE, flrd_pkg::SYNC_B);
        send_frame(8'h02, 8'h3C, 16'h0103, 8'h11, 8'h22, 16'd2, FLAW_NONE);
    endtask

    task automatic test_enable_drop();
        fill_body(6);
        send_frame(8'h02, 8'h3C, 16'h0200, 8'h33, 8'h44, 16'd6, FLAW_CUT);
        drain_results(SETTLE);
        write_reg(flrd_pkg::CFG_RX_ENABLE, 8'h01);
        send_frame(8'h02, 8'h3C, 16'h0201, 8'h33, 8'h44, 16'd6, FLAW_NONE);
        drain_results(SETTLE);
        write_reg(flrd_pkg::CFG_RX_ENABLE, 8'h00);
        repeat (16) send_byte(flrd_pkg::OP_BYTE, 8'($urandom));
        send_frame(8'h02, 8'h3C, 16'h0202, 8'h33, 8'h44, 16'd6, FLAW_NONE);
        drain_results(SETTLE);
        write_reg(flrd_pkg::CFG_RX_ENABLE, 8'h01);
        send_frame(8'h02, 8'h3C, 16'h0203, 8'h33, 8'h44, 16'd6, FLAW_NONE);
    endtask

    // long payload while the receiver holds off, so the input backs up
    task automatic test_full_payload();
        fill_body(128);
        hold_request = 150;
        send_frame(8'h02, 8'h3C, 16'hBEEF, 8'h7F, 8'h80, 16'd128, FLAW_NONE);
        drain_results(0);
    endtask

    task automatic test_random_phase(int items, logic [7:0] address, logic [7:0] version);
        int          target;
        int          pick;
        int          n;
        logic [15:0] len;
        logic [7:0]  ver;
        logic [7:0]  adr;
        frame_flaw_t flaw;
        drain_results(SETTLE);
        write_reg(flrd_pkg::CFG_DEV_ADDR, address);
        write_reg(flrd_pkg::CFG_VERSION, version);
        target = bytes_sent + items;
        while (bytes_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                repeat ($urandom_range(1, 6))
                    send_byte(flrd_pkg::OP_BYTE,
                              ($urandom_range(0, 3) == 0) ? flrd_pkg::SYNC_A : 8'($urandom));
            end else if (pick < 12) begin
                send_byte(flrd_pkg::OP_RESYNC, 8'($urandom));
            end else begin
                if (pick < 16)
                    len = 16'($urandom_range(flrd_pkg::PAYLOAD_LIMIT + 1, 65535));
                else if ($urandom_range(0, 3) == 0)
                    len = 16'($urandom_range(0, 64));
                else
                    len = 16'($urandom_range(0, 8));
                fill_body((len <= flrd_pkg::PAYLOAD_LIMIT) ? int'(len) : 0);
                ver  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : want_version;
                adr  = ($urandom_range(0, 6) == 0) ? 8'($urandom) : own_address;
                n    = $urandom_range(0, 99);
                flaw = (pick < 16) ? FLAW_NONE : (n < 8) ? FLAW_CRC : (n < 14) ? FLAW_TAIL :
                       (n < 24) ? FLAW_CUT : (n < 28) ? FLAW_PAUSE : FLAW_NONE;
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3)) send_byte(flrd_pkg::OP_BYTE, flrd_pkg::SYNC_A);
                send_frame(ver, adr, 16'($urandom), 8'($urandom), 8'($urandom), len, flaw);
                if (flaw == FLAW_CUT && $urandom_range(0, 3) != 0)
                    send_byte(flrd_pkg::OP_RESYNC, 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_disabled_rx();
        test_header_extremes();
        test_frame_errors();
        test_sync_hunt();
        test_enable_drop();
        test_full_payload();
        test_random_phase(170, 8'h00, 8'h02);
        test_random_phase(160, 8'hFF, 8'hFF);
        test_random_phase(140, 8'($urandom), 8'h00);
        idling_on = 0;
        test_random_phase(140, 8'($urandom), 8'($urandom));
        drain_results(2 * SETTLE);
        $display("covered %0d frames in %0d byte transfers, %0d results checked, %0d mismatches",
                 frames_sent, bytes_sent, results_seen, errors);
        if (errors == 0)
            $display("framed_link_receive_deframer_test: done, clean");
        else
            $display("framed_link_receive_deframer_test: done, errors");
        $finish;
    end

endmodule
